// ===== src/c3f_pkg.sv =====
`timescale 1ns / 1ps
package c3f_pkg;

  // Widths fixed by the field definitions
  localparam int PIX_W    = 8;
  localparam int ROW_W    = 12;
  localparam int OCOL_W   = 11;
  localparam int COEF_W   = 15;
  localparam int WT_W     = 5;
  localparam int SCALE_W  = 17;
  localparam int LWID_W   = 12;
  localparam int FHGT_W   = 13;
  localparam int SUM_W    = 17;
  localparam int PROD_W   = SUM_W + SCALE_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MIN_SIZE      = 3;

  // Front-to-back queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_TOP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_MID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_BOT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_W    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_H   = 3'd5;

  // Reset values
  localparam logic [COEF_W-1:0]  COEFF_RST   = 15'd1057;
  localparam logic [SCALE_W-1:0] SCALE_RST   = 17'd7282;
  localparam logic [LWID_W-1:0]  LINE_W_RST  = 12'd640;
  localparam logic [FHGT_W-1:0]  FRAME_H_RST = 13'd480;

  // Rounding and clamp
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 35'sd32768;
  localparam int                       FRAC_W     = 16;
  localparam logic [PIX_W-1:0]         PIX_MAX    = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel_out;
    logic [ROW_W-1:0]  centre_row;
    logic [OCOL_W-1:0] centre_col;
    logic              frame_last;
  } out_item_t;

  typedef struct packed {
    logic [2:0][COEF_W-1:0] coeff;   // [0] top, [1] mid, [2] bottom
    logic [SCALE_W-1:0]     scale;
    logic [LWID_W-1:0]      line_width;
    logic [FHGT_W-1:0]      frame_height;
  } cfg_t;

  // taps[col][row]: col 0 oldest, row 0 top
  typedef struct packed {
    logic [2:0][2:0][PIX_W-1:0] taps;
    logic [ROW_W-1:0]           centre_row;
    logic [OCOL_W-1:0]          centre_col;
    logic                       frame_last;
  } win_item_t;

endpackage

// ===== src/conv3x3_clamp_filter.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// item      push / full               in_item_t  {pixel_in, frame_start}
// result    pop / empty               out_item_t {pixel_out, centre_row, centre_col, frame_last}
// config    cfg_valid / cfg_ready     cfg_index (3), cfg_data (17)
//
// One pixel per clock sustained while full is low. A result reaches the ports
// through registered steps after its pixel transfer, whose edge also reads the
// line store: window/queue push, sum, scale, clamp.
// Reset clears position, window and pipeline control; line stores are not
// cleared and are only read where already written, so no clearing pass.
// full rises when the four-entry queue between front and back cannot take
// another window; the back stalls stage by stage while pop is low.
module conv3x3_clamp_filter #(
  parameter int MAX_WIDTH = c3f_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  c3f_pkg::in_item_t                  item,
  output logic                               empty,
  input  logic                               pop,
  output c3f_pkg::out_item_t                 result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [c3f_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [c3f_pkg::CFG_DATA_W-1:0]     cfg_data
);

  c3f_pkg::cfg_t              cfg;
  logic                       q_push;
  logic                       q_pop;
  c3f_pkg::win_item_t         q_wr_data;
  c3f_pkg::win_item_t         q_rd_data;
  logic [c3f_pkg::Q_LVL_W-1:0] q_level;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coeff[0]     <= c3f_pkg::COEFF_RST;
      cfg.coeff[1]     <= c3f_pkg::COEFF_RST;
      cfg.coeff[2]     <= c3f_pkg::COEFF_RST;
      cfg.scale        <= c3f_pkg::SCALE_RST;
      cfg.line_width   <= c3f_pkg::LINE_W_RST;
      cfg.frame_height <= c3f_pkg::FRAME_H_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        c3f_pkg::REG_COEFF_TOP: cfg.coeff[0] <= cfg_data[c3f_pkg::COEF_W-1:0];
        c3f_pkg::REG_COEFF_MID: cfg.coeff[1] <= cfg_data[c3f_pkg::COEF_W-1:0];
        c3f_pkg::REG_COEFF_BOT: cfg.coeff[2] <= cfg_data[c3f_pkg::COEF_W-1:0];
        c3f_pkg::REG_SCALE:     cfg.scale    <= cfg_data[c3f_pkg::SCALE_W-1:0];
        c3f_pkg::REG_LINE_W: begin
          cfg.line_width <= cfg_data[c3f_pkg::LWID_W-1:0];
        end
        c3f_pkg::REG_FRAME_H: begin
          cfg.frame_height <= cfg_data[c3f_pkg::FHGT_W-1:0];
        end
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // front: position tracking, line stores, window, border classification
  c3f_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .cfg     (cfg),
    .q_level (q_level),
    .q_push  (q_push),
    .q_data  (q_wr_data)
  );

  // interior windows waiting for the arithmetic
  c3f_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .level   (q_level)
  );

  // back: weighted sum, scale, round and clamp, result register
  c3f_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_level (q_level),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  // front flow control must never overrun the queue
  a_q_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push && !q_pop |-> q_level < c3f_pkg::Q_LVL_W'(c3f_pkg::Q_DEPTH))
    else $error("window queue overflow");

  a_q_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_level != '0)
    else $error("window queue underflow");

  // full must hold off the front while the queue is at capacity
  a_full_at_cap: assert property (@(posedge clk) disable iff (rst)
    q_level == c3f_pkg::Q_LVL_W'(c3f_pkg::Q_DEPTH) |-> full)
    else $error("full low with queue at capacity");

endmodule

// ===== src/c3f_queue.sv =====
`timescale 1ns / 1ps
module c3f_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  c3f_pkg::win_item_t        wr_data,
  input  logic                      rd_en,
  output c3f_pkg::win_item_t        rd_data,
  output logic [c3f_pkg::Q_LVL_W-1:0] level
);

  c3f_pkg::win_item_t              slots [c3f_pkg::Q_DEPTH];
  logic [c3f_pkg::Q_PTR_W-1:0]     wr_ptr;
  logic [c3f_pkg::Q_PTR_W-1:0]     rd_ptr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + c3f_pkg::Q_LVL_W'(wr_en) - c3f_pkg::Q_LVL_W'(rd_en);
    end
  end

  assign rd_data = slots[rd_ptr];

endmodule

// ===== src/c3f_front.sv =====
`timescale 1ns / 1ps
module c3f_front #(
  parameter int MAX_WIDTH = c3f_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  c3f_pkg::in_item_t           item,
  input  c3f_pkg::cfg_t               cfg,
  input  logic [c3f_pkg::Q_LVL_W-1:0] q_level,
  output logic                        q_push,
  output c3f_pkg::win_item_t          q_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > c3f_pkg::LWID_W) ? WW : c3f_pkg::LWID_W;
  localparam int PW = c3f_pkg::PIX_W;
  localparam int HW = c3f_pkg::FHGT_W;

  logic          accept;
  logic [EW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [EW-1:0] lw_ext;
  logic [EW-1:0] c_cur;
  logic [EW-1:0] c_nxt;
  logic [HW-1:0] r_cur;
  logic [HW-1:0] r_nxt;
  logic          interior;
  logic [EW-1:0] c_m1;
  logic [HW-1:0] r_m1;
  logic          last;

  logic [CW-1:0]                col_pos;
  logic [c3f_pkg::ROW_W-1:0]    row_pos;

  // line store entry: [15:8] two rows up, [7:0] one row up
  logic [2*PW-1:0] line_mem [MAX_WIDTH];
  logic [2*PW-1:0] rd_q;
  logic [2*PW-1:0] rd_use;
  logic            fwd;
  logic [2*PW-1:0] fwd_data;

  // stage 1 (item read from line store)
  logic                       v1;
  logic                       int1;
  logic [CW-1:0]              col1;
  logic [PW-1:0]              pix1;
  logic [c3f_pkg::ROW_W-1:0]  crow1;
  logic [c3f_pkg::OCOL_W-1:0] ccol1;
  logic                       last1;

  logic [2:0][PW-1:0] win0;
  logic [2:0][PW-1:0] win1;
  logic [2:0][PW-1:0] col3;

  assign accept = push && !full;

  always_comb begin
    lw_ext = EW'(cfg.line_width);
    if (lw_ext < EW'(c3f_pkg::MIN_SIZE)) begin
      w_eff = EW'(c3f_pkg::MIN_SIZE);
    end else if (lw_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = lw_ext;
    end
    if (cfg.frame_height < HW'(c3f_pkg::MIN_SIZE)) begin
      h_eff = HW'(c3f_pkg::MIN_SIZE);
    end else if (cfg.frame_height > HW'(c3f_pkg::MAX_HEIGHT)) begin
      h_eff = HW'(c3f_pkg::MAX_HEIGHT);
    end else begin
      h_eff = cfg.frame_height;
    end

    // position of this pixel
    if (item.frame_start) begin
      c_cur = '0;
      r_cur = '0;
    end else begin
      c_cur = EW'(col_pos);
      r_cur = HW'(row_pos);
    end
    if (c_cur >= w_eff) begin
      c_cur = '0;
      r_cur = r_cur + 1'b1;
    end
    if (r_cur >= h_eff) begin
      r_cur = '0;
    end

    // position of the next pixel
    c_nxt = c_cur + 1'b1;
    r_nxt = r_cur;
    if (c_nxt >= w_eff) begin
      c_nxt = '0;
      r_nxt = r_cur + 1'b1;
      if (r_nxt >= h_eff) begin
        r_nxt = '0;
      end
    end

    interior = (r_cur >= HW'(2)) && (c_cur >= EW'(2));
    c_m1     = c_cur - 1'b1;
    r_m1     = r_cur - 1'b1;
    last     = (r_cur == h_eff - 1'b1) && (c_cur == w_eff - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      v1      <= 1'b0;
      win0    <= '0;
      win1    <= '0;
    end else begin
      v1 <= accept;
      if (accept) begin
        col_pos <= c_nxt[CW-1:0];
        row_pos <= r_nxt[c3f_pkg::ROW_W-1:0];
      end
      if (v1) begin
        win0 <= win1;
        win1 <= col3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q     <= line_mem[c_cur[CW-1:0]];
      fwd      <= v1 && (col1 == c_cur[CW-1:0]);
      fwd_data <= {rd_use[PW-1:0], pix1};
      int1     <= interior;
      col1     <= c_cur[CW-1:0];
      pix1     <= item.pixel_in;
      crow1    <= r_m1[c3f_pkg::ROW_W-1:0];
      ccol1    <= c_m1[c3f_pkg::OCOL_W-1:0];
      last1    <= last;
    end
    if (v1) begin
      line_mem[col1] <= {rd_use[PW-1:0], pix1};
    end
  end

  // same column written last cycle: take the pending write
  assign rd_use = fwd ? fwd_data : rd_q;
  assign col3   = {pix1, rd_use[PW-1:0], rd_use[2*PW-1:PW]};

  // room must remain for the item in stage 1 and this one
  assign full = (({1'b0, q_level} + (c3f_pkg::Q_LVL_W + 1)'(v1 && int1))
                >= (c3f_pkg::Q_LVL_W + 1)'(c3f_pkg::Q_DEPTH));

  assign q_push            = v1 && int1;
  assign q_data.taps       = {col3, win1, win0};
  assign q_data.centre_row = crow1;
  assign q_data.centre_col = ccol1;
  assign q_data.frame_last = last1;

endmodule

// ===== src/c3f_back.sv =====
`timescale 1ns / 1ps
module c3f_back (
  input  logic                        clk,
  input  logic                        rst,
  input  c3f_pkg::cfg_t               cfg,
  input  logic [c3f_pkg::Q_LVL_W-1:0] q_level,
  input  c3f_pkg::win_item_t          q_data,
  output logic                        q_pop,
  output logic                        empty,
  input  logic                        pop,
  output c3f_pkg::out_item_t          result
);

  localparam int SW = c3f_pkg::SUM_W;
  localparam int PW = c3f_pkg::PROD_W;
  localparam int RW = PW - c3f_pkg::FRAC_W;

  typedef struct packed {
    logic [c3f_pkg::ROW_W-1:0]  centre_row;
    logic [c3f_pkg::OCOL_W-1:0] centre_col;
    logic                       frame_last;
  } meta_t;

  logic                   b1_v, b2_v, out_v;
  logic                   b1_rdy, b2_rdy, out_rdy;
  logic signed [SW-1:0]   sum_c, sum_q;
  logic signed [PW-1:0]   prod_q;
  logic signed [PW-1:0]   rnd;
  logic [RW-1:0]          rnd_int;
  logic [c3f_pkg::PIX_W-1:0] pix_c;
  meta_t                  m1, m2;
  logic signed [13:0]     term;
  logic signed [c3f_pkg::WT_W-1:0] wt;

  assign out_rdy = !out_v || pop;
  assign b2_rdy  = !b2_v || out_rdy;
  assign b1_rdy  = !b1_v || b2_rdy;
  assign q_pop   = (q_level != '0) && b1_rdy;
  assign empty   = !out_v;

  // weighted sum of the nine taps
  always_comb begin
    sum_c = '0;
    term  = '0;
    wt    = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        wt    = $signed(cfg.coeff[r][c*c3f_pkg::WT_W +: c3f_pkg::WT_W]);
        term  = $signed({1'b0, q_data.taps[c][r]}) * wt;
        sum_c = sum_c + SW'(term);
      end
    end
  end

  // round half up, clamp to pixel range
  always_comb begin
    rnd     = prod_q + c3f_pkg::ROUND_HALF;
    rnd_int = rnd[PW-1:c3f_pkg::FRAC_W];
    if (prod_q[PW-1]) begin
      pix_c = '0;
    end else if (rnd_int > RW'(c3f_pkg::PIX_MAX)) begin
      pix_c = c3f_pkg::PIX_MAX;
    end else begin
      pix_c = rnd_int[c3f_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v  <= 1'b0;
      b2_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (b1_rdy) begin
        b1_v <= q_pop;
      end
      if (b2_rdy) begin
        b2_v <= b1_v;
      end
      if (out_rdy) begin
        out_v <= b2_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sum_q <= sum_c;
      m1    <= {q_data.centre_row, q_data.centre_col, q_data.frame_last};
    end
    if (b1_v && b2_rdy) begin
      prod_q <= sum_q * $signed({1'b0, cfg.scale});
      m2     <= m1;
    end
    if (b2_v && out_rdy) begin
      result.pixel_out  <= pix_c;
      result.centre_row <= m2.centre_row;
      result.centre_col <= m2.centre_col;
      result.frame_last <= m2.frame_last;
    end
  end

endmodule
